[src/scck_pkg.sv]
// ----------------------------------------------------------------------------
// scck_pkg: shared types and constants for the scc search block
// holds vertex limits, walk stack entry type and controller states
// ----------------------------------------------------------------------------
`default_nettype none
package scck_pkg;
  localparam int MAX_VERTICES = 32;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  localparam logic CFG_IDX_NUM_VERTICES = 1'b0;

  typedef struct packed {
    logic [VW-1:0] v;
    logic [CW-1:0] j;
  } stk_ent_t;

  typedef struct packed {
    logic [4:0] vertex;
    logic [4:0] component;
    logic       last_in_component;
    logic       last_of_run;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_P1_NEXT,
    ST_P2_NEXT,
    ST_RD,
    ST_SCAN,
    ST_FLUSH
  } state_t;
endpackage
`default_nettype wire

[src/scck_if.sv]
// ----------------------------------------------------------------------------
// scck channel interfaces
// valid/ready channels for edge/run items and for emitted vertices
// ----------------------------------------------------------------------------
`default_nettype none
interface scck_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [4:0] src_vertex;
  logic [4:0] dst_vertex;
  modport source (output valid, kind, src_vertex, dst_vertex, input ready);
  modport sink (input valid, kind, src_vertex, dst_vertex, output ready);
endinterface

interface scck_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] vertex;
  logic [4:0] component;
  logic       last_in_component;
  logic       last_of_run;
  modport source (output valid, vertex, component, last_in_component, last_of_run,
                  input ready);
  modport sink (input valid, vertex, component, last_in_component, last_of_run,
                output ready);
endinterface
`default_nettype wire

[src/scc_kosaraju_matrix.sv]
// ----------------------------------------------------------------------------
// scc_kosaraju_matrix: strongly connected components of a small graph
// adjacency and transposed adjacency in synchronous rams, kosaraju search
// ----------------------------------------------------------------------------
// usage:
//  in_ch carries one transaction per item: kind 0 adds the edge src->dst
//  (ignored when either vertex is not below num_vertices), kind 1 runs the
//  component search. out_ch returns one transaction per vertex of a run,
//  in second-pass preorder, with component index and end marks.
//  an edge item goes through accept, row read and row write back before
//  the next item is taken. a run does each walk step as a registered ram
//  read of the row followed by its scan, roughly 4*n stack steps for n
//  vertices. each result leaves one emit later than found since its end
//  marks are known only then. reset clears the matrices through per-row
//  valid bits, with no clearing pass, and sets num_vertices to 32.
//  when out_ch stalls the walk waits at the next emit; input is taken
//  only when no run is in progress.
//  config: apb write of num_vertices at byte address 0 while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module scc_kosaraju_matrix
  import scck_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  scck_in_if.sink     in_ch,
  scck_out_if.source  out_ch,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration register
  logic [5:0] num_vertices_r;
  logic [CW-1:0] n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vertices_r <= 6'd32;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == CFG_IDX_NUM_VERTICES) begin
      num_vertices_r <= cfg_pwdata[5:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_NUM_VERTICES) ?
                      {26'd0, num_vertices_r} : 32'd0;

  always_comb begin
    if ({1'b0, num_vertices_r} > 7'(MAX_VERTICES)) n = CW'(MAX_VERTICES);
    else n = CW'(num_vertices_r);
  end

  // control registers
  state_t state_r, state_nxt;
  logic [CW-1:0] depth_r, depth_nxt;
  logic [CW-1:0] fc_r, fc_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [4:0] comp_r, comp_nxt;
  logic [MAX_VERTICES-1:0] vis_r, vis_nxt;
  logic pass_r, pass_nxt;
  logic [VW-1:0] es_r, es_nxt, ed_r, ed_nxt;
  logic pend_vld_r, pend_vld_nxt;
  res_t pend_r, pend_nxt;
  logic out_vld_r, out_vld_nxt;
  res_t out_r, out_nxt;

  // adjacency rams with per-row valid bits
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adjt_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rv_r, adjt_rv_r;
  logic [MAX_VERTICES-1:0] adj_q_r, adjt_q_r;
  logic adj_qv_r, adjt_qv_r;
  logic rd_en, wr_en;
  logic [VW-1:0] adj_ra, adjt_ra;
  logic [MAX_VERTICES-1:0] adj_row, adjt_row, row;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      adj_q_r  <= adj_mem[adj_ra];
      adjt_q_r <= adjt_mem[adjt_ra];
    end
    if (wr_en) begin
      adj_mem[es_r]  <= adj_row | (MAX_VERTICES'(1) << ed_r);
      adjt_mem[ed_r] <= adjt_row | (MAX_VERTICES'(1) << es_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_rv_r  <= '0;
      adjt_rv_r <= '0;
      adj_qv_r  <= 1'b0;
      adjt_qv_r <= 1'b0;
    end else begin
      if (rd_en) begin
        adj_qv_r  <= adj_rv_r[adj_ra];
        adjt_qv_r <= adjt_rv_r[adjt_ra];
      end
      if (wr_en) begin
        adj_rv_r[es_r]  <= 1'b1;
        adjt_rv_r[ed_r] <= 1'b1;
      end
    end
  end

  assign adj_row  = adj_qv_r ? adj_q_r : '0;
  assign adjt_row = adjt_qv_r ? adjt_q_r : '0;
  assign row      = pass_r ? adjt_row : adj_row;

  // walk and finish stacks
  stk_ent_t walk_stk [MAX_VERTICES];
  logic [VW-1:0] fin_stk [MAX_VERTICES];
  logic stk_upd_en, stk_push_en, fin_we;
  logic [VW-1:0] stk_upd_idx, stk_push_idx, fin_idx;
  stk_ent_t stk_upd_d, stk_push_d;
  logic [VW-1:0] fin_d;
  logic [CW-1:0] depth_m1, fc_m1;
  stk_ent_t top;

  assign depth_m1 = depth_r - CW'(1);
  assign fc_m1    = fc_r - CW'(1);
  assign top      = walk_stk[depth_m1[VW-1:0]];

  always_ff @(posedge clk) begin
    if (stk_upd_en) walk_stk[stk_upd_idx] <= stk_upd_d;
    if (stk_push_en) walk_stk[stk_push_idx] <= stk_push_d;
    if (fin_we) fin_stk[fin_idx] <= fin_d;
  end

  // first unvisited neighbor at or above the scan position
  logic [MAX_VERTICES-1:0] cand;
  logic found;
  logic [VW-1:0] fnd;

  always_comb begin
    cand = '0;
    for (int k = 0; k < MAX_VERTICES; k++) begin
      cand[k] = row[k] & ~vis_r[k] & (CW'(k) >= top.j) & (CW'(k) < n);
    end
    found = |cand;
    fnd = '0;
    for (int k = MAX_VERTICES - 1; k >= 0; k--) begin
      if (cand[k]) fnd = VW'(k);
    end
  end

  logic out_free, stall;
  logic [VW-1:0] p2v;
  assign out_free = !out_vld_r || out_ch.ready;
  assign stall    = pend_vld_r && !out_free;
  assign p2v      = fin_stk[fc_m1[VW-1:0]];

  // next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    depth_nxt    = depth_r;
    fc_nxt       = fc_r;
    idx_nxt      = idx_r;
    comp_nxt     = comp_r;
    vis_nxt      = vis_r;
    pass_nxt     = pass_r;
    es_nxt       = es_r;
    ed_nxt       = ed_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_nxt      = out_r;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    adj_ra       = top.v;
    adjt_ra      = top.v;
    stk_upd_en   = 1'b0;
    stk_upd_idx  = depth_m1[VW-1:0];
    stk_upd_d    = top;
    stk_push_en  = 1'b0;
    stk_push_idx = depth_r[VW-1:0];
    stk_push_d   = '0;
    fin_we       = 1'b0;
    fin_idx      = fc_r[VW-1:0];
    fin_d        = top.v;
    in_ch.ready  = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.kind == KIND_RUN) begin
            vis_nxt   = '0;
            fc_nxt    = '0;
            comp_nxt  = '0;
            idx_nxt   = '0;
            pass_nxt  = 1'b0;
            state_nxt = ST_P1_NEXT;
          end else if (CW'(in_ch.src_vertex) < n && CW'(in_ch.dst_vertex) < n) begin
            es_nxt    = in_ch.src_vertex[VW-1:0];
            ed_nxt    = in_ch.dst_vertex[VW-1:0];
            state_nxt = ST_EDGE_RD;
          end
        end
      end
      ST_EDGE_RD: begin
        rd_en     = 1'b1;
        adj_ra    = es_r;
        adjt_ra   = ed_r;
        state_nxt = ST_EDGE_WR;
      end
      ST_EDGE_WR: begin
        wr_en     = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_P1_NEXT: begin
        if (idx_r >= n) begin
          vis_nxt   = '0;
          pass_nxt  = 1'b1;
          state_nxt = ST_P2_NEXT;
        end else if (vis_r[idx_r[VW-1:0]]) begin
          idx_nxt = idx_r + CW'(1);
        end else begin
          vis_nxt[idx_r[VW-1:0]] = 1'b1;
          stk_push_en  = 1'b1;
          stk_push_idx = '0;
          stk_push_d   = '{v: idx_r[VW-1:0], j: '0};
          depth_nxt    = CW'(1);
          state_nxt    = ST_RD;
        end
      end
      ST_P2_NEXT: begin
        if (fc_r == '0) begin
          state_nxt = pend_vld_r ? ST_FLUSH : ST_IDLE;
        end else if (vis_r[p2v]) begin
          fc_nxt = fc_m1;
        end else if (!stall) begin
          if (pend_vld_r) begin
            out_nxt     = pend_r;
            out_vld_nxt = 1'b1;
          end
          pend_vld_nxt  = 1'b1;
          pend_nxt      = '{vertex: 5'(p2v), component: comp_r,
                            last_in_component: 1'b0, last_of_run: 1'b0};
          vis_nxt[p2v]  = 1'b1;
          stk_push_en   = 1'b1;
          stk_push_idx  = '0;
          stk_push_d    = '{v: p2v, j: '0};
          depth_nxt     = CW'(1);
          fc_nxt        = fc_m1;
          state_nxt     = ST_RD;
        end
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (found) begin
          if (!(pass_r && stall)) begin
            stk_upd_en = 1'b1;
            stk_upd_d  = '{v: top.v, j: CW'(fnd) + CW'(1)};
            vis_nxt[fnd] = 1'b1;
            if (pass_r) begin
              if (pend_vld_r) begin
                out_nxt     = pend_r;
                out_vld_nxt = 1'b1;
              end
              pend_vld_nxt = 1'b1;
              pend_nxt     = '{vertex: 5'(fnd), component: comp_r,
                               last_in_component: 1'b0, last_of_run: 1'b0};
            end
            if (depth_r < CW'(MAX_VERTICES)) begin
              stk_push_en = 1'b1;
              stk_push_d  = '{v: fnd, j: '0};
              depth_nxt   = depth_r + CW'(1);
            end
            state_nxt = ST_RD;
          end
        end else begin
          depth_nxt = depth_m1;
          if (!pass_r && fc_r < CW'(MAX_VERTICES)) begin
            fin_we = 1'b1;
            fc_nxt = fc_r + CW'(1);
          end
          if (depth_r == CW'(1)) begin
            if (pass_r) begin
              pend_nxt.last_in_component = 1'b1;
              comp_nxt  = comp_r + 5'd1;
              state_nxt = ST_P2_NEXT;
            end else begin
              state_nxt = ST_P1_NEXT;
            end
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_nxt             = pend_r;
          out_nxt.last_of_run = 1'b1;
          out_vld_nxt         = 1'b1;
          pend_vld_nxt        = 1'b0;
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      depth_r    <= '0;
      fc_r       <= '0;
      idx_r      <= '0;
      comp_r     <= '0;
      vis_r      <= '0;
      pass_r     <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      depth_r    <= depth_nxt;
      fc_r       <= fc_nxt;
      idx_r      <= idx_nxt;
      comp_r     <= comp_nxt;
      vis_r      <= vis_nxt;
      pass_r     <= pass_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    es_r   <= es_nxt;
    ed_r   <= ed_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.vertex            = out_r.vertex;
  assign out_ch.component         = out_r.component;
  assign out_ch.last_in_component = out_r.last_in_component;
  assign out_ch.last_of_run       = out_r.last_of_run;

  // checks
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CW'(MAX_VERTICES))
    else $error("walk depth above vertex limit");
  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= CW'(MAX_VERTICES))
    else $error("finish count above vertex limit");
  a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && out_free) |=> (out_vld_r && out_r.last_of_run && !pend_vld_r))
    else $error("run end not flagged");
  a_idle_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_vld_r)
    else $error("held result left over at idle");

endmodule
`default_nettype wire
